@@ src/nbg_pkg.sv @@
// Shared types, constants and helpers of the n-body gravity step block.
package nbg_pkg;

   // Value format and derived widths.
   localparam int VAL_W     = 48;
   localparam int IDX_FW    = 4;
   localparam int WIDE_W    = 128;
   localparam int MUL_W     = 64;
   localparam int DATA_W    = 296;
   localparam int PAD_W     = DATA_W - IDX_FW - 6 * VAL_W;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 32;
   localparam int COUNT_W   = 5;

   typedef logic signed [VAL_W-1:0] val_type;
   typedef val_type [2:0] vec3_type;

   localparam val_type VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam val_type VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   localparam logic [CSR_W-1:0]   G_RESET     = 32'd214748365;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd6;

   // State held by one cell of the body ring.
   typedef struct packed {
      vec3_type pos;
      vec3_type vel;
      vec3_type acc;
   } body_type;

   // Per-cell controls.
   typedef struct packed {
      logic shift;
      logic load;
      logic acc_wr;
   } cell_ctl_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_G_FACTOR,
      CSR_BODY_COUNT
   } csr_index_type;

   typedef enum logic {
      OP_LOAD,
      OP_STEP
   } op_type;

   typedef enum logic {
      KIND_BODY,
      KIND_BARY
   } kind_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ROW,
      S_COL,
      S_SQ_GO,
      S_SQ_WAIT,
      S_RT_GO,
      S_RT_WAIT,
      S_DSQ_GO,
      S_DSQ_WAIT,
      S_COS_GO,
      S_COS_WAIT,
      S_GM_GO,
      S_GM_WAIT,
      S_TRM_GO,
      S_TRM_WAIT,
      S_NEXTJ,
      S_ROWEND,
      S_ROWADV,
      S_UPD,
      S_BAR_GO,
      S_BAR_WAIT,
      S_BAR_OUT
   } state_type;

   // Saturating add of two values.
   function automatic val_type sat_add(val_type a, val_type b);
      logic [VAL_W:0] s;
      s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
      if (s[VAL_W] != s[VAL_W-1]) begin
         return s[VAL_W] ? VAL_MIN : VAL_MAX;
      end
      return val_type'(s[VAL_W-1:0]);
   endfunction

endpackage

@@ src/nbg_cell.sv @@
// One cell of the body ring: holds position, velocity and acceleration of one body.
module nbg_cell import nbg_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  body_type     shift_in,
   input  body_type     load_in,
   input  vec3_type     acc_in,
   output body_type     state_out
);

   body_type body_ff, body_in;

   // A load writes position and velocity; a shift takes the neighbor's state.
   always_comb begin
      body_in = body_ff;
      if (ctl.load) begin
         body_in.pos = load_in.pos;
         body_in.vel = load_in.vel;
      end else if (ctl.shift) begin
         body_in = shift_in;
      end else if (ctl.acc_wr) begin
         body_in.acc = acc_in;
      end
   end

   always_ff @(posedge clock) begin
      body_ff <= body_in;
   end

   assign state_out = body_ff;

endmodule

@@ src/nbg_mul.sv @@
// Shift-and-add multiplier, one multiplier bit per cycle.
module nbg_mul #(
   parameter int AW = 64,
   parameter int BW = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [AW-1:0]   a,
   input  logic [BW-1:0]   b,
   output logic            done,
   output logic [AW+BW-1:0] prod
);

   localparam int CW = $clog2(BW);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [AW+BW-1:0] mcand_ff, mcand_in;
   logic [BW-1:0]   mplier_ff, mplier_in;
   logic [AW+BW-1:0] prod_ff, prod_in;

   // One partial product is added per cycle.
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      if (start) begin
         mcand_in  = {{BW{1'b0}}, a};
         mplier_in = b;
         prod_in   = '0;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            prod_in = prod_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == CW'(BW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

@@ src/nbg_div.sv @@
// Restoring divider, one quotient bit per cycle.
module nbg_div #(
   parameter int W = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] num,
   input  logic [W-1:0] den,
   output logic         done,
   output logic [W-1:0] quo
);

   localparam int CW = $clog2(W);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  den_ff, den_in;
   logic [W:0]    trial;

   // Shift in one numerator bit, subtract the divisor where it fits.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quo_ff[W-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

@@ src/nbg_sqrt.sv @@
// Integer square root, one result bit per cycle.
module nbg_sqrt #(
   parameter int W = 128
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [W-1:0]   rad,
   output logic           done,
   output logic [W/2-1:0] root
);

   localparam int CW = $clog2(W / 2);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  res_ff, res_in;
   logic [W-1:0]  one_ff, one_in;
   logic [W-1:0]  trial;

   // The result and the trial bit never overlap, so the trial is an OR.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      one_in  = one_ff;
      trial   = res_ff | one_ff;
      if (start) begin
         rem_in  = rad;
         res_in  = '0;
         one_in  = W'(1) << (W - 2);
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) | one_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         one_in = one_ff >> 2;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W / 2 - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
      one_ff <= one_in;
   end

   assign done = done_ff;
   assign root = res_ff[W/2-1:0];

endmodule

@@ src/n_body_gravity_step_top.sv @@
// Direct-sum n-body gravity stepper: body ring, pair sequencer and result register.
//
// Input beats (req_) carry an operation in req_tuser: a load writes one body's position
// and velocity; a step runs one Euler step over bodies 0..body_count-1, with body_count
// clamped to 1..MAX_BODIES. A step returns one beat per body (rsp_tuser = body) in index
// order and then the barycentre beat with rsp_tlast high. The csr_ port writes gravity
// strength (index 0) and body count (index 1); it is always ready. The user is to write
// it only between steps; the block itself does not enforce this. The bodies sit in a ring
// of MAX_BODIES cells that rotates by one cell per move; the arithmetic works on the cell
// at the head. Every interacting pair runs three squarings, a square root, a squaring of
// the distance, and per axis two divisions and a product, with a start and a done state
// around each unit. For each body in use the ring turns twice (once for body 0) so that
// the pulls are summed in body order. After the rows come the update beats and
// three divisions for the barycentre. Only one item is in work at a time:
// req_tready is high only between items.
// A stalled receiver holds the result register and the step waits on it.
// Reset restores the register defaults and idles the block; body contents are
// undefined until loaded, and there is no clearing pass.
module n_body_gravity_step_top import nbg_pkg::*; #(
   parameter int MAX_BODIES    = 16,
   parameter int FRACTION_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // body_index[3:0], pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, zero pad
   input  logic [DATA_W-1:0]    req_tdata,
   // operation
   input  logic                 req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // out_index[3:0], new_pos_x/y/z, new_vel_x/y/z, zero pad
   output logic [DATA_W-1:0]    rsp_tdata,
   // kind
   output logic                 rsp_tuser,
   output logic                 rsp_tlast,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   localparam int IDX_W  = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
   localparam int N_W    = $clog2(MAX_BODIES + 1);
   localparam int SUM_W  = VAL_W + N_W + 1;
   localparam int COS_W  = FRACTION_BITS + 1;
   localparam int GSHIFT = 2 * FRACTION_BITS - 32;
   localparam int DIST_W = VAL_W + 2;

   // Control state.
   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    head_idx_ff, head_idx_in, head_next;
   logic [IDX_W-1:0]    cur_i_ff, cur_i_in;
   logic [N_W-1:0]      n_ff, n_in;
   logic [1:0]          comp_ff, comp_in;
   logic [1:0]          lap_ff, lap_in, lap_next;
   logic [CSR_W-1:0]    g_ff, g_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   // Pair datapath registers.
   vec3_type            pi_ff, pi_in;
   vec3_type            acc_ff, acc_in;
   logic [2:0][VAL_W:0] mag_ff, mag_in;
   logic [2:0]          neg_ff, neg_in;
   logic [WIDE_W-1:0]   s_ff, s_in, s_sum;
   logic [DIST_W-1:0]   dist_ff, dist_in;
   logic [WIDE_W-1:0]   dsq_ff, dsq_in;
   logic [COS_W-1:0]    cos_ff, cos_in;
   logic [WIDE_W-1:0]   gnum_ff, gnum_in;
   logic [2:0][SUM_W-1:0] sum_ff, sum_in;
   vec3_type            bary_ff, bary_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_user_ff, rsp_user_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_free, rsp_load;

   // Ring signals.
   body_type            cell_q [MAX_BODIES];
   body_type            cell_d [MAX_BODIES];
   cell_ctl_type        cell_ctl [MAX_BODIES];
   body_type            head, head_upd, tail_d, load_body;
   logic                rotate, upd_rotate, load_en, acc_wr;

   // Combinational helpers.
   logic [2:0][VAL_W:0] diff_w, mag_w;
   val_type             term_mag, term;
   logic [SUM_W-1:0]    sum_mag;
   logic                sum_neg;
   val_type             bar_q;

   // Arithmetic units.
   logic                mul_start, mul_done;
   logic [MUL_W-1:0]    mul_a, mul_b;
   logic [WIDE_W-1:0]   mul_prod;
   logic                div_start, div_done;
   logic [WIDE_W-1:0]   div_num, div_den, div_quo;
   logic                rt_start, rt_done;
   logic [WIDE_W/2-1:0] rt_root;

   // Load beat unpacked into a body.
   always_comb begin
      load_body     = '0;
      load_body.pos[0] = val_type'(req_tdata[IDX_FW + 0*VAL_W +: VAL_W]);
      load_body.pos[1] = val_type'(req_tdata[IDX_FW + 1*VAL_W +: VAL_W]);
      load_body.pos[2] = val_type'(req_tdata[IDX_FW + 2*VAL_W +: VAL_W]);
      load_body.vel[0] = val_type'(req_tdata[IDX_FW + 3*VAL_W +: VAL_W]);
      load_body.vel[1] = val_type'(req_tdata[IDX_FW + 4*VAL_W +: VAL_W]);
      load_body.vel[2] = val_type'(req_tdata[IDX_FW + 5*VAL_W +: VAL_W]);
   end

   // Euler update of the head body, and the value the tail takes on a rotate.
   assign head = cell_q[0];
   always_comb begin
      head_upd = head;
      for (int c = 0; c < 3; c++) begin
         head_upd.vel[c] = sat_add(head.vel[c], head.acc[c]);
         head_upd.pos[c] = sat_add(head.pos[c], head_upd.vel[c]);
      end
      tail_d = upd_rotate ? head_upd : head;
   end

   // The ring of body cells.
   for (genvar k = 0; k < MAX_BODIES; k++) begin : g_ring
      if (k == MAX_BODIES - 1) begin : g_tail
         assign cell_d[k] = tail_d;
      end else begin : g_mid
         assign cell_d[k] = cell_q[k+1];
      end
      assign cell_ctl[k].shift  = rotate;
      assign cell_ctl[k].load   = load_en && (int'(req_tdata[IDX_FW-1:0]) == k);
      assign cell_ctl[k].acc_wr = acc_wr && (k == 0);
      nbg_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl[k]),
         .shift_in  (cell_d[k]),
         .load_in   (load_body),
         .acc_in    (acc_ff),
         .state_out (cell_q[k])
      );
   end

   // Separation of the head body from body i.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         diff_w[c] = {head.pos[c][VAL_W-1], head.pos[c]} - {pi_ff[c][VAL_W-1], pi_ff[c]};
         mag_w[c]  = diff_w[c][VAL_W] ? (~diff_w[c] + 1'b1) : diff_w[c];
      end
   end

   // Clamped pull term and barycentre magnitude for the current axis.
   always_comb begin
      if (div_quo > WIDE_W'(VAL_MAX)) begin
         term_mag = VAL_MAX;
      end else begin
         term_mag = val_type'(div_quo[VAL_W-1:0]);
      end
      term    = neg_ff[comp_ff] ? -term_mag : term_mag;
      sum_neg = sum_ff[comp_ff][SUM_W-1];
      sum_mag = sum_neg ? (~sum_ff[comp_ff] + 1'b1) : sum_ff[comp_ff];
      bar_q   = val_type'(div_quo[VAL_W-1:0]);
   end

   // Operand selection for the shared units.
   always_comb begin
      case (state_ff)
         S_DSQ_GO: begin
            mul_a = MUL_W'(dist_ff);
            mul_b = MUL_W'(dist_ff);
         end
         S_GM_GO: begin
            mul_a = MUL_W'(g_ff);
            mul_b = MUL_W'(cos_ff);
         end
         default: begin
            mul_a = MUL_W'(mag_ff[comp_ff]);
            mul_b = MUL_W'(mag_ff[comp_ff]);
         end
      endcase
      case (state_ff)
         S_TRM_GO: begin
            div_num = gnum_ff;
            div_den = dsq_ff;
         end
         S_BAR_GO: begin
            div_num = WIDE_W'(sum_mag);
            div_den = WIDE_W'(n_ff);
         end
         default: begin
            div_num = WIDE_W'(mag_ff[comp_ff]) << FRACTION_BITS;
            div_den = WIDE_W'(dist_ff);
         end
      endcase
   end

   nbg_mul #(.AW(MUL_W), .BW(MUL_W)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   nbg_div #(.W(WIDE_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   nbg_sqrt #(.W(WIDE_W)) u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (rt_start),
      .rad   (s_ff),
      .done  (rt_done),
      .root  (rt_root)
   );

   // Step sequencer.
   assign head_next = (head_idx_ff == IDX_W'(MAX_BODIES - 1)) ? '0 : head_idx_ff + 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign s_sum     = s_ff + mul_prod;

   // A row turns the ring to body 0, sums pulls over one full turn, then returns to body i.
   assign lap_next  = (head_next == '0) ? lap_ff + 2'd1 : lap_ff;

   always_comb begin
      state_in    = state_ff;
      head_idx_in = head_idx_ff;
      cur_i_in    = cur_i_ff;
      n_in        = n_ff;
      comp_in     = comp_ff;
      lap_in      = lap_ff;
      pi_in       = pi_ff;
      acc_in      = acc_ff;
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      s_in        = s_ff;
      dist_in     = dist_ff;
      dsq_in      = dsq_ff;
      cos_in      = cos_ff;
      gnum_in     = gnum_ff;
      sum_in      = sum_ff;
      bary_in     = bary_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_last_in = rsp_last_ff;
      rsp_load    = 1'b0;
      rotate      = 1'b0;
      upd_rotate  = 1'b0;
      load_en     = 1'b0;
      acc_wr      = 1'b0;
      mul_start   = 1'b0;
      div_start   = 1'b0;
      rt_start    = 1'b0;
      req_tready  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == OP_STEP) begin
                  if (count_ff == '0) begin
                     n_in = N_W'(1);
                  end else if (32'(count_ff) > MAX_BODIES) begin
                     n_in = N_W'(MAX_BODIES);
                  end else begin
                     n_in = N_W'(count_ff);
                  end
                  state_in = S_ROW;
               end else begin
                  load_en = 1'b1;
               end
            end
         end
         S_ROW: begin
            cur_i_in = head_idx_ff;
            pi_in    = head.pos;
            acc_in   = '0;
            lap_in   = (head_idx_ff == '0) ? 2'd1 : 2'd0;
            if (N_W'(head_idx_ff) < n_ff) begin
               state_in = S_COL;
            end else begin
               state_in = S_ROWADV;
            end
         end
         S_COL: begin
            if (lap_ff != 2'd1 || head_idx_ff == cur_i_ff || N_W'(head_idx_ff) >= n_ff) begin
               state_in = S_NEXTJ;
            end else begin
               for (int c = 0; c < 3; c++) begin
                  mag_in[c] = mag_w[c];
                  neg_in[c] = diff_w[c][VAL_W];
               end
               s_in     = '0;
               comp_in  = '0;
               state_in = S_SQ_GO;
            end
         end
         S_SQ_GO: begin
            mul_start = 1'b1;
            state_in  = S_SQ_WAIT;
         end
         S_SQ_WAIT: begin
            if (mul_done) begin
               s_in = s_sum;
               if (comp_ff == 2'd2) begin
                  comp_in  = '0;
                  state_in = (s_sum == '0) ? S_NEXTJ : S_RT_GO;
               end else begin
                  comp_in  = comp_ff + 1'b1;
                  state_in = S_SQ_GO;
               end
            end
         end
         S_RT_GO: begin
            rt_start = 1'b1;
            state_in = S_RT_WAIT;
         end
         S_RT_WAIT: begin
            if (rt_done) begin
               dist_in  = rt_root[DIST_W-1:0];
               state_in = S_DSQ_GO;
            end
         end
         S_DSQ_GO: begin
            mul_start = 1'b1;
            state_in  = S_DSQ_WAIT;
         end
         S_DSQ_WAIT: begin
            if (mul_done) begin
               dsq_in   = mul_prod;
               state_in = S_COS_GO;
            end
         end
         S_COS_GO: begin
            div_start = 1'b1;
            state_in  = S_COS_WAIT;
         end
         S_COS_WAIT: begin
            if (div_done) begin
               cos_in   = div_quo[COS_W-1:0];
               state_in = S_GM_GO;
            end
         end
         S_GM_GO: begin
            mul_start = 1'b1;
            state_in  = S_GM_WAIT;
         end
         S_GM_WAIT: begin
            if (mul_done) begin
               gnum_in  = mul_prod << GSHIFT;
               state_in = S_TRM_GO;
            end
         end
         S_TRM_GO: begin
            div_start = 1'b1;
            state_in  = S_TRM_WAIT;
         end
         S_TRM_WAIT: begin
            if (div_done) begin
               acc_in[comp_ff] = sat_add(acc_ff[comp_ff], term);
               if (comp_ff == 2'd2) begin
                  comp_in  = '0;
                  state_in = S_NEXTJ;
               end else begin
                  comp_in  = comp_ff + 1'b1;
                  state_in = S_COS_GO;
               end
            end
         end
         S_NEXTJ: begin
            rotate   = 1'b1;
            lap_in   = lap_next;
            state_in = (head_next == cur_i_ff && lap_next == 2'd2) ? S_ROWEND : S_COL;
         end
         S_ROWEND: begin
            acc_wr   = 1'b1;
            state_in = S_ROWADV;
         end
         S_ROWADV: begin
            rotate = 1'b1;
            if (cur_i_ff == IDX_W'(MAX_BODIES - 1)) begin
               sum_in   = '0;
               state_in = S_UPD;
            end else begin
               state_in = S_ROW;
            end
         end
         S_UPD: begin
            if (N_W'(head_idx_ff) < n_ff) begin
               if (rsp_free) begin
                  rotate      = 1'b1;
                  upd_rotate  = 1'b1;
                  rsp_load    = 1'b1;
                  rsp_user_in = KIND_BODY;
                  rsp_last_in = 1'b0;
                  rsp_data_in = {{PAD_W{1'b0}}, head_upd.vel[2], head_upd.vel[1],
                                 head_upd.vel[0], head_upd.pos[2], head_upd.pos[1],
                                 head_upd.pos[0], IDX_FW'(head_idx_ff)};
                  for (int c = 0; c < 3; c++) begin
                     sum_in[c] = sum_ff[c] + {{(SUM_W-VAL_W){head_upd.pos[c][VAL_W-1]}},
                                              head_upd.pos[c]};
                  end
               end
            end else begin
               rotate = 1'b1;
            end
            if (rotate && head_idx_ff == IDX_W'(MAX_BODIES - 1)) begin
               comp_in  = '0;
               state_in = S_BAR_GO;
            end
         end
         S_BAR_GO: begin
            div_start = 1'b1;
            state_in  = S_BAR_WAIT;
         end
         S_BAR_WAIT: begin
            if (div_done) begin
               bary_in[comp_ff] = sum_neg ? -bar_q : bar_q;
               if (comp_ff == 2'd2) begin
                  comp_in  = '0;
                  state_in = S_BAR_OUT;
               end else begin
                  comp_in  = comp_ff + 1'b1;
                  state_in = S_BAR_GO;
               end
            end
         end
         S_BAR_OUT: begin
            if (rsp_free) begin
               rsp_load    = 1'b1;
               rsp_user_in = KIND_BARY;
               rsp_last_in = 1'b1;
               rsp_data_in = {{PAD_W{1'b0}}, {(3*VAL_W){1'b0}}, bary_ff[2], bary_ff[1],
                              bary_ff[0], {IDX_FW{1'b0}}};
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rotate) begin
         head_idx_in = head_next;
      end
   end

   // Result register valid flag.
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // Configuration registers.
   assign csr_ready = 1'b1;
   always_comb begin
      g_in     = g_ff;
      count_in = count_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_G_FACTOR:   g_in     = csr_data;
            CSR_BODY_COUNT: count_in = csr_data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_idx_ff  <= '0;
         comp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         g_ff         <= G_RESET;
         count_ff     <= COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         head_idx_ff  <= head_idx_in;
         comp_ff      <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
         g_ff         <= g_in;
         count_ff     <= count_in;
      end
      cur_i_ff    <= cur_i_in;
      n_ff        <= n_in;
      lap_ff      <= lap_in;
      pi_ff       <= pi_in;
      acc_ff      <= acc_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      s_ff        <= s_in;
      dist_ff     <= dist_in;
      dsq_ff      <= dsq_in;
      cos_ff      <= cos_in;
      gnum_ff     <= gnum_in;
      sum_ff      <= sum_in;
      bary_ff     <= bary_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The ring must be back at body 0 whenever loads can arrive.
   a_ring_aligned: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> head_idx_ff == '0)
      else $error("body ring not aligned while idle");

   // The axis counter never runs past the z axis.
   a_comp_range: assert property (@(posedge clock) disable iff (reset)
      comp_ff != 2'd3)
      else $error("axis counter out of range");

   // Only the barycentre beat closes a step.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == KIND_BARY)
      else $error("last beat is not the barycentre");

   // The body count in use stays within the ring during a step.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE && $past(state_ff) != S_IDLE |->
         n_ff != '0 && n_ff <= N_W'(MAX_BODIES))
      else $error("body count in use out of range");

endmodule
